// ----- sv/crc64e_pkg.sv -----
`default_nettype none

package crc64e_pkg;

  localparam int unsigned CrcW      = 64;
  localparam int unsigned DataW     = 32;
  localparam int unsigned CountW    = 3;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned DataBytes = DataW / ByteW;

  typedef logic [CrcW-1:0] crc_t;

  // ECMA-182, bit-reversed
  localparam crc_t PolyReset = 64'hC96C_5795_D787_0F42;
  localparam crc_t SeedReset = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [0:0] {
    CfgPoly = 1'b0,
    CfgSeed = 1'b1
  } cfg_reg_e;

  // One LSB-first shift of the remainder with feedback.
  function automatic crc_t crc_shift(crc_t value, crc_t poly);
    return (value >> 1) ^ (poly & {CrcW{value[0]}});
  endfunction

endpackage

`default_nettype wire

// ----- sv/crc64e_in_if.sv -----
`default_nettype none

interface crc64e_in_if;
  import crc64e_pkg::*;

  logic              valid;
  logic              ready;
  logic [DataW-1:0]  data_bytes;
  logic [CountW-1:0] byte_count;
  logic              start_flag;
  logic              last_flag;

  modport source (
    output valid, data_bytes, byte_count, start_flag, last_flag,
    input  ready
  );

  modport sink (
    input  valid, data_bytes, byte_count, start_flag, last_flag,
    output ready
  );

endinterface

`default_nettype wire

// ----- sv/crc64e_out_if.sv -----
`default_nettype none

interface crc64e_out_if;
  import crc64e_pkg::*;

  logic valid;
  logic ready;
  crc_t checksum;

  modport source (
    output valid, checksum,
    input  ready
  );

  modport sink (
    input  valid, checksum,
    output ready
  );

endinterface

`default_nettype wire

// ----- sv/crc64_ecma_reflected_engine.sv -----
`default_nettype none

// Reflected CRC-64 (CRC-64/XZ at reset) over a byte stream, up to
// BYTE_LANES bytes per beat, lowest byte first. Throughput is one beat per
// cycle: the whole beat is folded combinationally into the 64-bit remainder
// by BYTE_LANES byte lanes whose terms are XOR-merged with the
// shifted remainder; the remainder register is the only loop. The checksum
// of a beat marked last appears on the output in the cycle after it is taken.
// The output register lets the next beat in during the cycle the checksum
// is taken; while the checksum waits unread, input ready stays low. After
// reset and after every polynomial write, the tap table is rebuilt one shift
// per cycle over all 8*BYTE_LANES taps, during which input ready stays low.
// Configuration writes are taken at any time.
module crc64_ecma_reflected_engine #(
  parameter int unsigned BYTE_LANES = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  crc64e_pkg::cfg_reg_e  cfg_idx_i,
  input  crc64e_pkg::crc_t      cfg_wdata_i,
  crc64e_in_if.sink             in_i,
  crc64e_out_if.source          out_o
);
  import crc64e_pkg::*;

  localparam int unsigned TapCount = ByteW * BYTE_LANES;
  localparam int unsigned CntW     = $clog2(BYTE_LANES + 1);

  crc_t            taps [TapCount];
  logic            tab_busy;
  logic            poly_load;

  crc_t            seed_q, seed_d;
  crc_t            rem_q, rem_d;
  logic            out_valid_q, out_valid_d;
  crc_t            sum_q, sum_d;

  logic            in_acc;
  logic [CountW:0] cnt_wide;
  logic [CntW-1:0] cnt_sat;
  crc_t            base;
  crc_t            term [BYTE_LANES];
  crc_t            rem_new;

  assign poly_load = cfg_we_i && (cfg_idx_i == CfgPoly);

  crc64e_tab #(
    .TapCount (TapCount)
  ) u_tab (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (poly_load),
    .poly_i (cfg_wdata_i),
    .busy_o (tab_busy),
    .taps_o (taps)
  );

  assign in_i.ready = !tab_busy && (!out_valid_q || out_o.ready);
  assign in_acc     = in_i.valid && in_i.ready;

  // Saturate the count to the lane count.
  assign cnt_wide = {1'b0, in_i.byte_count};
  assign cnt_sat  = (cnt_wide > (CountW+1)'(BYTE_LANES)) ? CntW'(BYTE_LANES)
                                                          : CntW'(cnt_wide);

  assign base = in_i.start_flag ? seed_q : rem_q;

  for (genvar k = 0; k < BYTE_LANES; k++) begin : g_lane
    logic [ByteW-1:0] lane_byte;
    if (k < DataBytes) begin : g_data
      assign lane_byte = base[ByteW*k +: ByteW] ^ in_i.data_bytes[ByteW*k +: ByteW];
    end else begin : g_pad
      // lanes past the data field absorb zero bytes
      assign lane_byte = base[ByteW*k +: ByteW];
    end

    crc64e_lane #(
      .Lanes   (BYTE_LANES),
      .LaneIdx (k)
    ) u_lane (
      .byte_i  (lane_byte),
      .count_i (cnt_sat),
      .taps_i  (taps),
      .term_o  (term[k])
    );
  end

  // Merge: bits above the absorbed span just shift down.
  always_comb begin
    rem_new = base >> (ByteW * cnt_sat);
    for (int k = 0; k < BYTE_LANES; k++) begin
      rem_new = rem_new ^ term[k];
    end
  end

  always_comb begin
    seed_d      = seed_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    sum_d       = sum_q;
    if (cfg_we_i && (cfg_idx_i == CfgSeed)) begin
      seed_d = cfg_wdata_i;
    end
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (in_acc) begin
      rem_d = rem_new;
      if (in_i.last_flag) begin
        out_valid_d = 1'b1;
        sum_d       = rem_new ^ seed_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= SeedReset;
      rem_q       <= SeedReset;
      out_valid_q <= 1'b0;
    end else begin
      seed_q      <= seed_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.checksum = sum_q;

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.last_flag |=> out_valid_q && (sum_q == $past(rem_new ^ seed_q)))
    else $error("last beat did not produce its checksum");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_i.last_flag && !out_o.ready |=> out_valid_q == $past(out_valid_q))
    else $error("non-last beat changed the output slot");

  a_start_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.start_flag && (cnt_sat == '0) |=> rem_q == $past(seed_q))
    else $error("start with no bytes did not reload the seed");

endmodule

`default_nettype wire

// ----- sv/crc64e_tab.sv -----
`default_nettype none

// Builds the feedback taps for the current polynomial: after a build,
// taps_o[TapCount-1-k] holds the polynomial carried through k further shifts.
module crc64e_tab #(
  parameter int unsigned TapCount = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  crc64e_pkg::crc_t  poly_i,
  output logic              busy_o,
  output crc64e_pkg::crc_t  taps_o [TapCount]
);
  import crc64e_pkg::*;

  localparam int unsigned CntW = $clog2(TapCount + 1);

  crc_t            poly_q, poly_d;
  crc_t            gen_q, gen_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  crc_t            taps_q [TapCount];

  assign busy_o = (cnt_q != '0);

  always_comb begin
    poly_d = poly_q;
    gen_d  = gen_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      poly_d = poly_i;
      gen_d  = poly_i;
      cnt_d  = CntW'(TapCount);
    end else if (busy_o) begin
      gen_d = crc_shift(gen_q, poly_q);
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= PolyReset;
      gen_q  <= PolyReset;
      cnt_q  <= CntW'(TapCount);
    end else begin
      poly_q <= poly_d;
      gen_q  <= gen_d;
      cnt_q  <= cnt_d;
    end
  end

  // Shift line: the first generated word ends up at the far end.
  always_ff @(posedge clk_i) begin
    if (busy_o) begin
      taps_q[0] <= gen_q;
    end
  end

  for (genvar j = 1; j < TapCount; j++) begin : g_shift
    always_ff @(posedge clk_i) begin
      if (busy_o) begin
        taps_q[j] <= taps_q[j-1];
      end
    end
  end

  assign taps_o = taps_q;

  a_load_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> cnt_q == CntW'(TapCount))
    else $error("table build did not restart on polynomial write");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o && !load_i |=> cnt_q == CntW'($past(cnt_q) - 1'b1))
    else $error("table build counter skipped");

  a_poly_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_i |=> $stable(poly_q))
    else $error("polynomial changed without a write");

endmodule

`default_nettype wire

// ----- sv/crc64e_lane.sv -----
`default_nettype none

// One byte lane: folds the lane's eight remainder bits through the taps
// that match their distance from the end of the item.
module crc64e_lane #(
  parameter int unsigned Lanes   = 4,
  parameter int unsigned LaneIdx = 0
) (
  input  logic [crc64e_pkg::ByteW-1:0]   byte_i,
  input  logic [$clog2(Lanes+1)-1:0]     count_i,
  input  crc64e_pkg::crc_t               taps_i [crc64e_pkg::ByteW*Lanes],
  output crc64e_pkg::crc_t               term_o
);
  import crc64e_pkg::*;

  localparam int unsigned CntW = $clog2(Lanes + 1);

  crc_t cand [Lanes+1];

  for (genvar m = 0; m <= Lanes; m++) begin : g_cnt
    if (m > LaneIdx) begin : g_used
      crc_t acc;
      always_comb begin
        acc = '0;
        for (int j = 0; j < ByteW; j++) begin
          if (byte_i[j]) begin
            acc = acc ^ taps_i[ByteW*(Lanes-m+LaneIdx)+j];
          end
        end
      end
      assign cand[m] = acc;
    end else begin : g_idle
      // lane lies beyond the byte count
      assign cand[m] = '0;
    end
  end

  always_comb begin
    term_o = '0;
    for (int m = 0; m <= Lanes; m++) begin
      if (count_i == CntW'(m)) begin
        term_o = cand[m];
      end
    end
  end

endmodule

`default_nettype wire
